@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// consequence must hold in the cycle after the trigger
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg)

`endif

`endif

@@ rtl/core/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg
// types, register codes and phase codes of the i2c master byte engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cm_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd1;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd20;
    localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

    // command opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // engine phases
    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_START_A    = 4'd1;
    localparam logic [3:0] PH_START_B    = 4'd2;
    localparam logic [3:0] PH_STOP_A     = 4'd3;
    localparam logic [3:0] PH_STOP_B     = 4'd4;
    localparam logic [3:0] PH_WR_SETUP   = 4'd5;
    localparam logic [3:0] PH_WR_HIGH    = 4'd6;
    localparam logic [3:0] PH_WR_LOW     = 4'd7;
    localparam logic [3:0] PH_ACK_SETTLE = 4'd8;
    localparam logic [3:0] PH_ACK_RISE   = 4'd9;
    localparam logic [3:0] PH_ACK_POLL   = 4'd10;
    localparam logic [3:0] PH_RD_LOW     = 4'd11;
    localparam logic [3:0] PH_RD_HIGH    = 4'd12;
    localparam logic [3:0] PH_RA_SETUP   = 4'd13;
    localparam logic [3:0] PH_RA_HIGH    = 4'd14;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic       cmd_valid;
        logic [1:0] opcode;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_in_word;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_oe;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_error;
    } t_out_word;

    typedef struct packed {
        logic [3:0]  phase;
        logic [3:0]  bit_count;
        logic [15:0] delay_count;
        logic [7:0]  shift_reg;
        logic [7:0]  poll_count;
        logic        scl;
        logic        sda;
        logic        oe;
        logic        ack_choice;
        logic        error_flag;
        logic [7:0]  rx_hold;
    } t_state;

    typedef struct packed {
        logic [15:0] half_period;
        logic [7:0]  ack_timeout;
    } t_cfg;

    localparam t_state STATE_RESET = '{
        phase:       PH_IDLE,
        bit_count:   4'd0,
        delay_count: 16'd0,
        shift_reg:   8'd0,
        poll_count:  8'd0,
        scl:         1'b1,
        sda:         1'b1,
        oe:          1'b1,
        ack_choice:  1'b0,
        error_flag:  1'b0,
        rx_hold:     8'd0
    };

endpackage

@@ rtl/core/i2c_master_byte_engine.sv @@
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// i2c master that runs start, stop, write byte and read byte commands
// ----------------------------------------------------------------------------
// usage:
//   each input word is one engine tick: command fields plus the sampled sda
//   level. each accepted word yields exactly one output word with the bus
//   drive levels, busy, a one-tick done pulse, the last received byte and
//   the acknowledge error flag after that tick.
//   channels use valid / stall; a word moves when valid is high and stall
//   is low. config writes (index 0 half period, index 1 ack timeout) use
//   valid / ready, ready is always high; write only while the engine idles.
//   path: an accepted word sits in the input register and is moved through
//   the step logic into the result register once that register is free.
//   throughput: one word per clock while output stall is low; the state update
//   for a tick is a single pass through the step logic between the two registers.
//   output stall: the result register holds, the input register fills, and
//   input stall rises only once both are occupied.
//   reset: engine idle, scl and sda high and driven, half period 20 ticks,
//   ack timeout 250 polls, both pipeline registers empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2c_master_byte_engine
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg      w_cfg;
    t_state    r_state;
    t_state    n_state;
    t_out_word n_out;
    t_in_word  r_in;
    logic      r_in_valid;
    t_out_word r_out;
    logic      r_out_valid;
    logic      w_out_free;
    logic      w_adv;
    logic      w_in_take;

    assign o_cfg_ready = 1'b1;

    i2cm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    i2cm_step u_step (
        .i_cur  (r_state),
        .i_word (r_in),
        .i_cfg  (w_cfg),
        .o_nxt  (n_state),
        .o_word (n_out)
    );

    // result register frees when empty or being taken this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_in_data;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_ALWAYS(a_done_ends_busy, i_clk, i_rst_n,
        !(o_out_valid && o_out_data.done_res && o_out_data.busy_res), "done word still busy")
    `ASSERT_ALWAYS(a_released_sda_high, i_clk, i_rst_n,
        !(o_out_valid && !o_out_data.sda_oe && !o_out_data.sda_out),
        "released sda reported low")
    `ASSERT_ALWAYS(a_poll_lines, i_clk, i_rst_n,
        (r_state.phase != PH_ACK_POLL) || (r_state.scl && !r_state.oe),
        "ack poll without scl high and sda released")
    `ASSERT_NEXT(a_write_clears_err, i_clk, i_rst_n,
        w_adv && r_in.cmd_valid && (r_in.opcode == OP_WRITE) && (r_state.phase == PH_IDLE),
        !r_state.error_flag && (r_state.phase == PH_WR_SETUP),
        "write command did not clear error")

endmodule

@@ rtl/core/i2cm_cfg.sv @@
// ----------------------------------------------------------------------------
// i2cm_cfg
// configuration registers: scl half period and acknowledge timeout
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cm_cfg
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [1:0]  i_index,
    input  logic [15:0] i_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period <= HALF_PERIOD_RESET;
            r_cfg.ack_timeout <= ACK_TIMEOUT_RESET;
        end else if (i_wr_en) begin
            unique case (i_index)
                CFG_HALF_PERIOD: r_cfg.half_period <= i_data;
                CFG_ACK_TIMEOUT: r_cfg.ack_timeout <= i_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/i2cm_step.sv @@
// ----------------------------------------------------------------------------
// i2cm_step
// one tick of the bus engine: next state and result word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cm_step
    import i2cm_pkg::*;
(
    input  t_state    i_cur,
    input  t_in_word  i_word,
    input  t_cfg      i_cfg,
    output t_state    o_nxt,
    output t_out_word o_word
);

    // move to a phase, restart the delay and set the line levels
    function automatic t_state f_enter(t_state s, logic [3:0] ph,
                                       logic scl, logic sda, logic oe);
        t_state r;
        r             = s;
        r.phase       = ph;
        r.delay_count = 16'd0;
        r.scl         = scl;
        r.oe          = oe;
        r.sda         = oe ? sda : 1'b1;
        return r;
    endfunction

    logic [15:0] w_half;
    logic [15:0] w_delay_inc;
    logic        w_delay_end;
    logic [3:0]  w_bits_inc;
    logic [7:0]  w_shift_wr;
    logic        w_done;
    t_state      w_nxt;

    // a zero half period behaves as one tick
    assign w_half      = (i_cfg.half_period == 16'd0) ? 16'd1 : i_cfg.half_period;
    assign w_delay_inc = i_cur.delay_count + 16'd1;
    assign w_delay_end = (w_delay_inc >= w_half);
    assign w_bits_inc  = i_cur.bit_count + 4'd1;
    assign w_shift_wr  = {i_cur.shift_reg[6:0], 1'b0};

    always_comb begin
        w_nxt  = i_cur;
        w_done = 1'b0;
        if (i_cur.phase == PH_IDLE) begin
            if (i_word.cmd_valid) begin
                unique case (i_word.opcode)
                    OP_START: w_nxt = f_enter(i_cur, PH_START_A, 1'b1, 1'b1, 1'b1);
                    OP_STOP:  w_nxt = f_enter(i_cur, PH_STOP_A, 1'b0, 1'b0, 1'b1);
                    OP_WRITE: begin
                        w_nxt            = f_enter(i_cur, PH_WR_SETUP, 1'b0,
                                                   i_word.tx_byte[7], 1'b1);
                        w_nxt.error_flag = 1'b0;
                        w_nxt.shift_reg  = i_word.tx_byte;
                        w_nxt.bit_count  = 4'd0;
                    end
                    default: begin
                        w_nxt            = f_enter(i_cur, PH_RD_LOW, 1'b0, 1'b1, 1'b0);
                        w_nxt.shift_reg  = 8'd0;
                        w_nxt.bit_count  = 4'd0;
                        w_nxt.ack_choice = i_word.send_ack;
                    end
                endcase
            end
        end else if (i_cur.phase == PH_ACK_POLL) begin
            if (!i_word.sda_in) begin
                w_nxt  = f_enter(i_cur, PH_IDLE, 1'b0, 1'b1, 1'b0);
                w_done = 1'b1;
            end else if (i_cur.poll_count >= i_cfg.ack_timeout) begin
                w_nxt            = f_enter(i_cur, PH_STOP_A, 1'b0, 1'b0, 1'b1);
                w_nxt.error_flag = 1'b1;
            end else begin
                w_nxt.poll_count = i_cur.poll_count + 8'd1;
            end
        end else begin
            w_nxt.delay_count = w_delay_inc;
            if (w_delay_end) begin
                unique case (i_cur.phase)
                    PH_START_A: w_nxt = f_enter(i_cur, PH_START_B, 1'b1, 1'b0, 1'b1);
                    PH_START_B: begin
                        w_nxt  = f_enter(i_cur, PH_IDLE, 1'b0, 1'b0, 1'b1);
                        w_done = 1'b1;
                    end
                    PH_STOP_A: w_nxt = f_enter(i_cur, PH_STOP_B, 1'b1, 1'b1, 1'b1);
                    PH_STOP_B: begin
                        w_nxt  = f_enter(i_cur, PH_IDLE, 1'b1, 1'b1, 1'b1);
                        w_done = 1'b1;
                    end
                    PH_WR_SETUP: w_nxt = f_enter(i_cur, PH_WR_HIGH, 1'b1, i_cur.sda, 1'b1);
                    PH_WR_HIGH:  w_nxt = f_enter(i_cur, PH_WR_LOW, 1'b0, i_cur.sda, 1'b1);
                    PH_WR_LOW: begin
                        if (w_bits_inc < BITS_PER_BYTE) begin
                            w_nxt = f_enter(i_cur, PH_WR_SETUP, 1'b0, w_shift_wr[7], 1'b1);
                        end else begin
                            w_nxt = f_enter(i_cur, PH_ACK_SETTLE, 1'b0, 1'b1, 1'b0);
                        end
                        w_nxt.bit_count = w_bits_inc;
                        w_nxt.shift_reg = w_shift_wr;
                    end
                    PH_ACK_SETTLE: w_nxt = f_enter(i_cur, PH_ACK_RISE, 1'b1, 1'b1, 1'b0);
                    PH_ACK_RISE: begin
                        w_nxt            = f_enter(i_cur, PH_ACK_POLL, 1'b1, 1'b1, 1'b0);
                        w_nxt.poll_count = 8'd0;
                    end
                    PH_RD_LOW: begin
                        w_nxt           = f_enter(i_cur, PH_RD_HIGH, 1'b1, 1'b1, 1'b0);
                        w_nxt.shift_reg = {i_cur.shift_reg[6:0], i_word.sda_in};
                    end
                    PH_RD_HIGH: begin
                        if (w_bits_inc < BITS_PER_BYTE) begin
                            w_nxt = f_enter(i_cur, PH_RD_LOW, 1'b0, 1'b1, 1'b0);
                        end else begin
                            w_nxt = f_enter(i_cur, PH_RA_SETUP, 1'b0,
                                            ~i_cur.ack_choice, 1'b1);
                            w_nxt.rx_hold = i_cur.shift_reg;
                        end
                        w_nxt.bit_count = w_bits_inc;
                    end
                    PH_RA_SETUP: w_nxt = f_enter(i_cur, PH_RA_HIGH, 1'b1, i_cur.sda, 1'b1);
                    PH_RA_HIGH: begin
                        w_nxt  = f_enter(i_cur, PH_IDLE, 1'b0, i_cur.sda, 1'b1);
                        w_done = 1'b1;
                    end
                    // unused phase code falls back to idle with lines held
                    default: w_nxt = f_enter(i_cur, PH_IDLE, i_cur.scl, i_cur.sda, i_cur.oe);
                endcase
            end
        end
    end

    assign o_nxt = w_nxt;

    assign o_word.scl_out   = w_nxt.scl;
    assign o_word.sda_out   = w_nxt.sda;
    assign o_word.sda_oe    = w_nxt.oe;
    assign o_word.busy_res  = (w_nxt.phase != PH_IDLE);
    assign o_word.done_res  = w_done;
    assign o_word.rx_byte   = w_nxt.rx_hold;
    assign o_word.ack_error = w_nxt.error_flag;

endmodule

@@ sim/i2c_master_byte_engine_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_test
// drives command and sda ticks into the i2c byte engine, predicts every
// output word from an in-bench model of the bus sequencer and compares them
// field by field, under random gaps, output stalls and a long hold-off
// ----------------------------------------------------------------------------

module i2c_master_byte_engine_test;
    import i2cm_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 7;
    localparam int CYCLE_LIMIT      = 3000000;
    localparam int HOLD_OFF_CYCLES  = 80;
    localparam int HOLD_OFF_AFTER   = 200;
    localparam int DRAIN_CYCLES     = 6;
    localparam int RANDOM_PER_PHASE = 4;
    localparam int QUIET_COMMANDS   = 4;

    // how sda_in behaves over one command
    localparam int SDA_NOISE = 0;
    localparam int SDA_HIGH  = 1;
    localparam int SDA_LOW   = 2;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_word    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_word   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_HALF_PERIOD;
    logic [15:0] i_cfg_data = '0;

    i2c_master_byte_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // predicted engine state and timing registers
    logic [15:0] cfg_half = HALF_PERIOD_RESET;
    logic [7:0]  cfg_tmo = ACK_TIMEOUT_RESET;
    logic [3:0]  eng_phase = PH_IDLE;
    logic [3:0]  bit_cnt = '0;
    logic [15:0] dly_cnt = '0;
    logic [7:0]  shreg = '0;
    logic [7:0]  polls = '0;
    logic        scl_q = 1'b1, sda_q = 1'b1, oe_q = 1'b1;
    logic        ack_sel = 1'b0, err_q = 1'b0;
    logic [7:0]  rx_q = '0;

    t_in_word    pending_ticks[$];
    t_out_word   predicted_words[$];

    int error_count = 0;
    int results_seen = 0;
    int commands_queued = 0;
    int ack_timeouts = 0;
    int cycle_count = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit in_taken = 1'b0;
    logic hold_on = 1'b0;
    logic quiet = 1'b0;

    function automatic void go_phase(input logic [3:0] ph, input logic scl, input logic sda,
                                     input logic oe);
        eng_phase = ph;
        dly_cnt = '0;
        scl_q = scl;
        oe_q = oe;
        sda_q = oe ? sda : 1'b1;
    endfunction

    // one engine tick; returns the bus word after the update
    function automatic t_out_word engine_tick(input t_in_word w);
        logic [15:0] half;
        logic        finished;
        t_out_word   r;
        half = (cfg_half == 16'd0) ? 16'd1 : cfg_half;
        finished = 1'b0;
        if (eng_phase == PH_IDLE) begin
            if (w.cmd_valid) begin
                case (w.opcode)
                    OP_START: go_phase(PH_START_A, 1'b1, 1'b1, 1'b1);
                    OP_STOP:  go_phase(PH_STOP_A, 1'b0, 1'b0, 1'b1);
                    OP_WRITE: begin
                        err_q = 1'b0;
                        shreg = w.tx_byte;
                        bit_cnt = '0;
                        go_phase(PH_WR_SETUP, 1'b0, w.tx_byte[7], 1'b1);
                    end
                    default: begin
                        shreg = '0;
                        bit_cnt = '0;
                        ack_sel = w.send_ack;
                        go_phase(PH_RD_LOW, 1'b0, 1'b1, 1'b0);
                    end
                endcase
            end
        end else if (eng_phase == PH_ACK_POLL) begin
            if (!w.sda_in) begin
                go_phase(PH_IDLE, 1'b0, 1'b1, 1'b0);
                finished = 1'b1;
            end else if (polls >= cfg_tmo) begin
                // no acknowledge in time: flag it and release the bus with a stop
                err_q = 1'b1;
                ack_timeouts++;
                go_phase(PH_STOP_A, 1'b0, 1'b0, 1'b1);
            end else begin
                polls = polls + 8'd1;
            end
        end else begin
            dly_cnt = dly_cnt + 16'd1;
            if (dly_cnt >= half) begin
                case (eng_phase)
                    PH_START_A: go_phase(PH_START_B, 1'b1, 1'b0, 1'b1);
                    PH_START_B: begin
                        go_phase(PH_IDLE, 1'b0, 1'b0, 1'b1);
                        finished = 1'b1;
                    end
                    PH_STOP_A: go_phase(PH_STOP_B, 1'b1, 1'b1, 1'b1);
                    PH_STOP_B: begin
                        go_phase(PH_IDLE, 1'b1, 1'b1, 1'b1);
                        finished = 1'b1;
                    end
                    PH_WR_SETUP: go_phase(PH_WR_HIGH, 1'b1, sda_q, 1'b1);
                    PH_WR_HIGH: go_phase(PH_WR_LOW, 1'b0, sda_q, 1'b1);
                    PH_WR_LOW: begin
                        bit_cnt = bit_cnt + 4'd1;
                        shreg = shreg << 1;
                        if (bit_cnt < BITS_PER_BYTE) begin
                            go_phase(PH_WR_SETUP, 1'b0, shreg[7], 1'b1);
                        end else begin
                            go_phase(PH_ACK_SETTLE, 1'b0, 1'b1, 1'b0);
                        end
                    end
                    PH_ACK_SETTLE: go_phase(PH_ACK_RISE, 1'b1, 1'b1, 1'b0);
                    PH_ACK_RISE: begin
                        polls = '0;
                        go_phase(PH_ACK_POLL, 1'b1, 1'b1, 1'b0);
                    end
                    PH_RD_LOW: begin
                        shreg = {shreg[6:0], w.sda_in};
                        go_phase(PH_RD_HIGH, 1'b1, 1'b1, 1'b0);
                    end
                    PH_RD_HIGH: begin
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt < BITS_PER_BYTE) begin
                            go_phase(PH_RD_LOW, 1'b0, 1'b1, 1'b0);
                        end else begin
                            rx_q = shreg;
                            go_phase(PH_RA_SETUP, 1'b0, !ack_sel, 1'b1);
                        end
                    end
                    PH_RA_SETUP: go_phase(PH_RA_HIGH, 1'b1, sda_q, 1'b1);
                    PH_RA_HIGH: begin
                        go_phase(PH_IDLE, 1'b0, sda_q, 1'b1);
                        finished = 1'b1;
                    end
                    default: go_phase(PH_IDLE, scl_q, sda_q, oe_q);
                endcase
            end
        end
        r.scl_out = scl_q;
        r.sda_out = sda_q;
        r.sda_oe = oe_q;
        r.busy_res = (eng_phase != PH_IDLE);
        r.done_res = finished;
        r.rx_byte = rx_q;
        r.ack_error = err_q;
        return r;
    endfunction

    function automatic void compare_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endfunction

    // output check first, then the input word taken at this edge
    always @(posedge i_clk) begin : monitor
        t_out_word want_word;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (predicted_words.size() == 0) begin
                $error("output word with nothing predicted");
                error_count++;
            end else begin
                want_word = predicted_words.pop_front();
                compare_field("scl_out", want_word.scl_out, o_out_data.scl_out);
                compare_field("sda_out", want_word.sda_out, o_out_data.sda_out);
                compare_field("sda_oe", want_word.sda_oe, o_out_data.sda_oe);
                compare_field("busy_res", want_word.busy_res, o_out_data.busy_res);
                compare_field("done_res", want_word.done_res, o_out_data.done_res);
                compare_field("rx_byte", want_word.rx_byte, o_out_data.rx_byte);
                compare_field("ack_error", want_word.ack_error, o_out_data.ack_error);
            end
        end
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_taken) begin
            predicted_words.push_back(engine_tick(i_in_data));
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (!quiet && !hold_on && $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(0, 13);
                i_in_valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
                i_in_data <= pending_ticks.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output stall, with one long hold-off so the pipeline backs up into the input
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_on <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            hold_on <= (hold_left != 0);
            i_out_stall <= 1'b1;
        end else if (!hold_done && !quiet && results_seen >= HOLD_OFF_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES - 1;
            hold_on <= 1'b1;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 13);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("i2c_master_byte_engine_test: done, errors");
            $finish;
        end
    end

    function automatic logic line_level(input int sda_mode);
        if (sda_mode == SDA_HIGH) begin
            return 1'b1;
        end else if (sda_mode == SDA_LOW) begin
            return 1'b0;
        end
        return 1'($urandom_range(0, 1));
    endfunction

    // one command word, then enough ticks that the engine is idle again
    task automatic queue_command(input logic [1:0] op, input logic [7:0] tx, input logic ack,
                                 input int sda_mode);
        t_in_word w;
        int       he;
        int       span;
        int       j;
        he = (cfg_half == 16'd0) ? 1 : int'(cfg_half);
        case (op)
            // 8 bits of 3 half periods, settle, rise, polls, then a possible stop
            OP_WRITE: span = 28 * he + int'(cfg_tmo) + 4;
            // 8 bits of 2 half periods plus the acknowledge clock
            OP_READ:  span = 18 * he + 2;
            default:  span = 2 * he + 1;
        endcase
        span += $urandom_range(0, 2);
        w.cmd_valid = 1'b1;
        w.opcode = op;
        w.tx_byte = tx;
        w.send_ack = ack;
        w.sda_in = line_level(sda_mode);
        pending_ticks.push_back(w);
        for (j = 1; j <= span; j++) begin
            // early ticks may carry commands the busy engine has to ignore
            w.cmd_valid = (j <= 2 * he) && ($urandom_range(0, 3) == 0);
            w.opcode = 2'($urandom_range(0, 3));
            w.tx_byte = 8'($urandom_range(0, 255));
            w.send_ack = 1'($urandom_range(0, 1));
            w.sda_in = line_level(sda_mode);
            pending_ticks.push_back(w);
        end
        commands_queued++;
    endtask

    task automatic queue_random_command();
        int pick;
        pick = $urandom_range(0, 9);
        queue_command(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)),
                      (pick < 6) ? SDA_NOISE : ((pick < 8) ? SDA_HIGH : SDA_LOW));
    endtask

    task automatic settle();
        do @(posedge i_clk);
        while (pending_ticks.size() != 0 || i_in_valid || predicted_words.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        if (idx == CFG_HALF_PERIOD) begin
            cfg_half = val;
        end else if (idx == CFG_ACK_TIMEOUT) begin
            cfg_tmo = val[7:0];
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_timing(input logic [15:0] half, input logic [7:0] tmo);
        write_reg(CFG_HALF_PERIOD, half);
        // upper byte is outside the timeout register
        write_reg(CFG_ACK_TIMEOUT, {8'($urandom_range(0, 255)), tmo});
    endtask

    initial begin
        int ph;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset timing: start and stop at the default half period
        queue_command(OP_START, 8'h00, 1'b0, SDA_NOISE);
        queue_command(OP_STOP, 8'hFF, 1'b1, SDA_NOISE);
        settle();

        // zero half period runs as one tick, zero timeout fails on the first high poll
        set_timing(16'd0, 8'd0);
        queue_command(OP_START, 8'h00, 1'b0, SDA_NOISE);
        queue_command(OP_WRITE, 8'h81, 1'b0, SDA_HIGH);
        queue_command(OP_WRITE, 8'h3C, 1'b1, SDA_LOW);
        queue_command(OP_READ, 8'h00, 1'b0, SDA_NOISE);
        queue_command(OP_STOP, 8'h00, 1'b0, SDA_NOISE);
        settle();

        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: set_timing(16'd1, 8'd0);
                1: set_timing(16'd2, 8'd3);
                default: set_timing(16'd1, 8'($urandom_range(0, 4)));
            endcase
            repeat (RANDOM_PER_PHASE) queue_random_command();
            settle();
        end

        quiet = 1'b1;
        set_timing(16'd1, 8'd2);
        repeat (QUIET_COMMANDS) queue_random_command();
        settle();

        $display("covered %0d commands over %0d engine ticks, %0d acknowledge timeouts",
                 commands_queued, results_seen, ack_timeouts);
        $display("timing ran from a zero half period to the reset default, with one long hold-off");
        if (error_count == 0 && predicted_words.size() == 0) begin
            $display("i2c_master_byte_engine_test: done, clean");
        end else begin
            $display("i2c_master_byte_engine_test: done, errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_cfg.sv
rtl/core/i2cm_step.sv
rtl/core/i2c_master_byte_engine.sv
sim/i2c_master_byte_engine_test.sv
